// ----- rtl/core/ima_adpcm_stereo_decoder_assert.svh -----
// assertion macros of the decoder rtl
`ifndef IMA_ADPCM_STEREO_DECODER_ASSERT_SVH
`define IMA_ADPCM_STEREO_DECODER_ASSERT_SVH

// condition in this cycle implies consequence in this cycle
`define IMASD_ASSERT_SAME(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("decoder check failed");

// condition in this cycle implies consequence in the next cycle
`define IMASD_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("decoder check failed");

`endif

// ----- rtl/core/imasd_pkg.sv -----
// types, constants and tables of the ima adpcm stereo decoder
package imasd_pkg;

  localparam int unsigned IdxMax = 88;

  localparam logic SEL_STEREO_MODE = 1'b0;
  localparam logic SEL_EIGHT_BIT   = 1'b1;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       channel;
    logic       restart;
    logic       end_of_block;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               sample_channel;
    logic               last_of_pair;
    logic               block_end;
  } out_beat_t;

  typedef struct packed {
    logic signed [15:0] pred;
    logic [6:0]         idx;
  } chan_state_t;

  localparam logic [14:0] STEP_TABLE [0:IdxMax] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  function automatic logic [14:0] step_of(input logic [6:0] idx);
    logic [6:0] i;
    i = (idx > 7'(IdxMax)) ? 7'(IdxMax) : idx;
    return STEP_TABLE[i];
  endfunction

  function automatic logic signed [4:0] index_move(input logic [2:0] mag);
    logic signed [4:0] mv;
    case (mag)
      3'd4:    mv = 5'sd2;
      3'd5:    mv = 5'sd4;
      3'd6:    mv = 5'sd6;
      3'd7:    mv = 5'sd8;
      default: mv = -5'sd1;
    endcase
    return mv;
  endfunction

endpackage

// ----- rtl/core/imasd_in_if.sv -----
// code byte channel: valid/ready with one input beat
interface imasd_in_if import imasd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/imasd_out_if.sv -----
// sample channel: valid/ready with one result beat
interface imasd_out_if import imasd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/imasd_nibble.sv -----
// one nibble decode step: predictor update, index update, output format
module imasd_nibble import imasd_pkg::*; (
  input  chan_state_t        cur,
  input  logic [3:0]         code,
  input  logic               eight_bit,
  output chan_state_t        nxt,
  output logic signed [15:0] sample
);

  logic [14:0]        step;
  logic [16:0]        diff;
  logic signed [17:0] sum;
  logic signed [15:0] sat;
  logic signed [7:0]  idx_sum;

  always_comb begin
    step = step_of(cur.idx);
    diff = {5'd0, step[14:3]};
    if (code[2]) diff = diff + {2'd0, step};
    if (code[1]) diff = diff + {3'd0, step[14:1]};
    if (code[0]) diff = diff + {4'd0, step[14:2]};

    if (code[3]) begin
      sum = 18'(cur.pred) - $signed({1'b0, diff});
    end else begin
      sum = 18'(cur.pred) + $signed({1'b0, diff});
    end

    if (sum > 18'sd32767) begin
      sat = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[15:0];
    end

    idx_sum = $signed({1'b0, cur.idx}) + 8'(index_move(code[2:0]));
    nxt.pred = sat;
    if (idx_sum < 8'sd0) begin
      nxt.idx = 7'd0;
    end else if (idx_sum > 8'(IdxMax)) begin
      nxt.idx = 7'(IdxMax);
    end else begin
      nxt.idx = idx_sum[6:0];
    end

    // 8-bit mode: offset-binary high byte
    if (eight_bit) begin
      sample = {8'd0, sat[15:8] ^ 8'h80};
    end else begin
      sample = sat;
    end
  end

endmodule

// ----- rtl/core/imasd_chan_regs.sv -----
// per-channel predictor and step index registers with restart clear
module imasd_chan_regs import imasd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        sel,
  input  logic        clear,
  input  logic        wr_en,
  input  chan_state_t wr_state,
  output chan_state_t rd_state
);

  chan_state_t state_r [2];

  // a restart reads as the cleared state; the write that follows stores the state decoded from it
  always_comb begin
    if (clear) begin
      rd_state = '0;
    end else begin
      rd_state = state_r[sel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r[0] <= '0;
      state_r[1] <= '0;
    end else if (wr_en) begin
      state_r[sel] <= wr_state;
    end
  end

endmodule

// ----- rtl/core/ima_adpcm_stereo_decoder.sv -----
// top level of the ima adpcm stereo decoder
//
//  port      dir   beat contents
//  in_chan   sink  code_byte, channel, restart, end_of_block
//  out_chan  src   sample_value, sample_channel, last_of_pair, block_end
//  cfg_*     in    write enable, register index, data (no read-back)
//
// each code byte gives two sample beats, one per cycle while out_chan does not stall;
// the two nibbles go through the single shared nibble decoder in turn.
// a taken byte is held in the input slot, and its first sample is then registered in the result register.
// rst_n is synchronous: it clears config, channel state and all valids.
// a stalled output holds the byte in the input slot; in_chan stays not ready meanwhile.
module ima_adpcm_stereo_decoder import imasd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  imasd_in_if.sink    in_chan,
  imasd_out_if.source out_chan,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  `include "ima_adpcm_stereo_decoder_assert.svh"

  logic        stereo_r;
  logic        eight_r;
  logic        slot_valid_r;
  in_beat_t    slot_r;
  logic        phase_r;
  logic        out_valid_r;
  out_beat_t   out_data_r;

  logic        advance;
  logic        in_fire;
  chan_state_t cur_state;
  chan_state_t nxt_state;
  logic signed [15:0] sample;
  logic [3:0]  code;

  assign advance        = slot_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !slot_valid_r || (advance && phase_r);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign code           = phase_r ? slot_r.code_byte[7:4] : slot_r.code_byte[3:0];
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r <= 1'b0;
      eight_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        SEL_STEREO_MODE: stereo_r <= cfg_data;
        SEL_EIGHT_BIT:   eight_r  <= cfg_data;
        default:         ;
      endcase
    end
  end

  imasd_chan_regs u_chan_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .sel      (slot_r.channel),
    .clear    (slot_r.restart && !phase_r),
    .wr_en    (advance),
    .wr_state (nxt_state),
    .rd_state (cur_state)
  );

  imasd_nibble u_nibble (
    .cur       (cur_state),
    .code      (code),
    .eight_bit (eight_r),
    .nxt       (nxt_state),
    .sample    (sample)
  );

  // input slot and nibble phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= 1'b0;
      phase_r      <= 1'b0;
    end else if (in_fire) begin
      slot_valid_r <= 1'b1;
      phase_r      <= 1'b0;
    end else if (advance) begin
      if (phase_r) begin
        slot_valid_r <= 1'b0;
      end else begin
        phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      // mono mode folds every byte onto the left channel
      slot_r <= '{code_byte:    in_chan.data.code_byte,
                  channel:      in_chan.data.channel & stereo_r,
                  restart:      in_chan.data.restart,
                  end_of_block: in_chan.data.end_of_block};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.sample_value   <= sample;
      out_data_r.sample_channel <= slot_r.channel;
      out_data_r.last_of_pair   <= phase_r;
      out_data_r.block_end      <= phase_r & slot_r.end_of_block;
    end
  end

  `IMASD_ASSERT_SAME(a_low_no_end, clk, rst_n,
    out_valid_r && !out_data_r.last_of_pair, !out_data_r.block_end)
  `IMASD_ASSERT_SAME(a_no_take_mid_byte, clk, rst_n,
    slot_valid_r && !phase_r, !in_chan.ready)
  `IMASD_ASSERT_NEXT(a_low_then_high, clk, rst_n,
    advance && !phase_r, slot_valid_r && phase_r && out_valid_r)
  `IMASD_ASSERT_NEXT(a_high_after_low, clk, rst_n,
    advance && phase_r, out_valid_r && out_data_r.last_of_pair)

endmodule
